### sv/ure_pkg.sv
// shared types and constants of the ultrasonic echo ranger
package ure_pkg;

    localparam int CMD_W      = 2;
    localparam int CH_W       = 2;
    localparam int KIND_W     = 2;
    localparam int DIST_W     = 17;
    localparam int MASK_W     = 4;
    localparam int TOUT_W     = 16;
    localparam int SPEED_W    = 6;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int DIST_SHIFT = 5;

    localparam logic [TOUT_W-1:0]    TIMEOUT_RST = 16'd60000;
    localparam logic [SPEED_W-1:0]   SPEED_RST   = 6'd11;
    localparam logic [DIST_W-1:0]    DIST_MAX    = '1;

    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED   = 2'd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK       = 2'd0,
        CMD_ARM        = 2'd1,
        CMD_ECHO_BEGIN = 2'd2,
        CMD_ECHO_END   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        MODE_IDLE       = 3'b001,
        MODE_WAIT_BEGIN = 3'b010,
        MODE_WAIT_END   = 3'b100
    } t_mode;

    typedef enum logic [KIND_W-1:0] {
        KIND_NONE    = 2'd0,
        KIND_MEAS    = 2'd1,
        KIND_TIMEOUT = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [CH_W-1:0]   result_channel;
        logic [DIST_W-1:0] distance_mm;
        logic [MASK_W-1:0] timeout_mask;
    } t_result;

endpackage

### sv/ure_cmd_if.sv
// command channel: tick, arm and echo event words
interface ure_cmd_if;
    import ure_pkg::*;

    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] command;
    logic [CH_W-1:0]  channel;

    modport source (output valid, output command, output channel, input ready);
    modport sink   (input valid, input command, input channel, output ready);
endinterface

### sv/ure_res_if.sv
// result channel: measurement and timeout words
interface ure_res_if;
    import ure_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [CH_W-1:0]   result_channel;
    logic [DIST_W-1:0] distance_mm;
    logic [MASK_W-1:0] timeout_mask;

    modport source (output valid, output kind, output result_channel,
                    output distance_mm, output timeout_mask, input ready);
    modport sink   (input valid, input kind, input result_channel,
                    input distance_mm, input timeout_mask, output ready);
endinterface

### sv/ultrasonic_echo_ranger.sv
// multi-channel ultrasonic echo ranger top level
//
// i_cmd takes one command word per handshake: a microsecond tick, an arm of
// a channel, or an echo begin / echo end event on a channel. every accepted
// word gives exactly one word on o_res: kind none, a measurement with the
// distance in millimetres, or a mask of channels re-armed after a timeout.
// i_cfg_we with i_cfg_idx writes the timeout (index 0) or the speed factor
// (index 1); write only while no word is in flight.
// the result word is registered in the output register, or in the skid
// register while the receiver stalls. throughput: one word per cycle while
// the output stage has room; the channel state update, the age compare of
// all channels and the width by speed multiply all finish in the accept cycle.
// a two-entry output stage (output register plus skid register) lets one more
// word in while the receiver stalls; i_cmd.ready drops only once both hold
// words and rises again as soon as the receiver takes one.
// reset (synchronous, active low) clears the time counter, puts every channel
// in idle, restores the register defaults and empties the output stage.
module ultrasonic_echo_ranger #(
    parameter int CHANNELS  = 4,
    parameter int TIME_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ure_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ure_pkg::CFG_W-1:0]     i_cfg_data,
    ure_cmd_if.sink                       i_cmd,
    ure_res_if.source                     o_res
);
    import ure_pkg::*;

    localparam int CMP_W  = (TIME_BITS > TOUT_W) ? TIME_BITS : TOUT_W;
    localparam int PROD_W = TIME_BITS + SPEED_W;
    localparam int SAT_W  = (PROD_W > DIST_W) ? PROD_W : DIST_W;
    localparam int MW     = (CHANNELS > MASK_W) ? CHANNELS : MASK_W;

    logic [TOUT_W-1:0]    r_timeout;
    logic [SPEED_W-1:0]   r_speed;
    logic [TIME_BITS-1:0] r_time,  n_time;
    t_mode                r_mode   [CHANNELS];
    t_mode                n_mode   [CHANNELS];
    logic [TIME_BITS-1:0] r_trig   [CHANNELS];
    logic [TIME_BITS-1:0] n_trig   [CHANNELS];
    logic [TIME_BITS-1:0] r_echo   [CHANNELS];
    logic [TIME_BITS-1:0] n_echo   [CHANNELS];

    t_result              r_out, r_skid, n_res;
    logic                 r_out_v, r_skid_v;

    logic                 w_in_fire, w_out_fire;
    logic [TIME_BITS-1:0] w_tick;
    logic [TIME_BITS-1:0] w_age    [CHANNELS];
    logic [CHANNELS-1:0]  w_hit;
    logic [TIME_BITS-1:0] w_sel_start;
    logic [TIME_BITS-1:0] w_width;
    logic [PROD_W-1:0]    w_prod;
    logic [SAT_W-1:0]     w_scaled;
    logic [DIST_W-1:0]    w_dist;
    logic [MW-1:0]        w_tmask;

    assign w_in_fire  = i_cmd.valid & i_cmd.ready;
    assign w_out_fire = r_out_v & o_res.ready;
    assign w_tick     = r_time + TIME_BITS'(1);

    // addressed channel and age of every channel against the advanced time
    always_comb begin
        w_sel_start = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            w_hit[c] = (c < (1 << CH_W)) && (i_cmd.channel == CH_W'(c));
            w_age[c] = w_tick - r_trig[c];
            if (w_hit[c]) begin
                w_sel_start = r_echo[c];
            end
        end
    end

    assign w_width  = r_time - w_sel_start;
    assign w_prod   = PROD_W'(w_width) * PROD_W'(r_speed);
    assign w_scaled = SAT_W'(w_prod >> DIST_SHIFT);
    assign w_dist   = (w_scaled > SAT_W'(DIST_MAX)) ? DIST_MAX : w_scaled[DIST_W-1:0];

    always_comb begin
        n_time  = r_time;
        n_mode  = r_mode;
        n_trig  = r_trig;
        n_echo  = r_echo;
        w_tmask = '0;
        n_res   = '{kind: KIND_NONE, result_channel: '0, distance_mm: '0, timeout_mask: '0};
        case (i_cmd.command)
            CMD_TICK: begin
                n_time = w_tick;
                for (int c = 0; c < CHANNELS; c++) begin
                    if (r_mode[c] == MODE_WAIT_END &&
                        CMP_W'(w_age[c]) > CMP_W'(r_timeout)) begin
                        n_trig[c]  = w_tick;
                        n_mode[c]  = MODE_WAIT_BEGIN;
                        w_tmask[c] = 1'b1;
                    end
                end
                n_res.timeout_mask = w_tmask[MASK_W-1:0];
                if (|w_tmask[MASK_W-1:0]) begin
                    n_res.kind = KIND_TIMEOUT;
                end
            end
            CMD_ARM: begin
                for (int c = 0; c < CHANNELS; c++) begin
                    if (w_hit[c]) begin
                        n_trig[c] = r_time;
                        n_mode[c] = MODE_WAIT_BEGIN;
                    end
                end
            end
            CMD_ECHO_BEGIN: begin
                for (int c = 0; c < CHANNELS; c++) begin
                    if (w_hit[c] && r_mode[c] == MODE_WAIT_BEGIN) begin
                        n_echo[c] = r_time;
                        n_mode[c] = MODE_WAIT_END;
                    end
                end
            end
            CMD_ECHO_END: begin
                for (int c = 0; c < CHANNELS; c++) begin
                    if (w_hit[c] && r_mode[c] == MODE_WAIT_END) begin
                        n_mode[c]            = MODE_IDLE;
                        n_res.kind           = KIND_MEAS;
                        n_res.result_channel = i_cmd.channel;
                        n_res.distance_mm    = w_dist;
                    end
                end
            end
            default: ;
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RST;
            r_speed   <= SPEED_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_TIMEOUT: r_timeout <= i_cfg_data[TOUT_W-1:0];
                REG_SPEED:   r_speed   <= i_cfg_data[SPEED_W-1:0];
                default: ;
            endcase
        end
    end

    // channel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_mode[c] <= MODE_IDLE;
                r_trig[c] <= '0;
                r_echo[c] <= '0;
            end
        end else if (w_in_fire) begin
            r_time <= n_time;
            r_mode <= n_mode;
            r_trig <= n_trig;
            r_echo <= n_echo;
        end
    end

    // output register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || w_out_fire) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v  <= w_in_fire;
            end
        end else if (w_in_fire) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || w_out_fire) begin
            r_out <= r_skid_v ? r_skid : n_res;
        end else if (w_in_fire) begin
            r_skid <= n_res;
        end
    end

    assign i_cmd.ready          = ~r_skid_v;
    assign o_res.valid          = r_out_v;
    assign o_res.kind           = r_out.kind;
    assign o_res.result_channel = r_out.result_channel;
    assign o_res.distance_mm    = r_out.distance_mm;
    assign o_res.timeout_mask   = r_out.timeout_mask;

endmodule

### sv/ure_checker.sv
// port-level checks of the echo ranger and their bind
module ure_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [ure_pkg::KIND_W-1:0]   i_kind,
    input logic [ure_pkg::CH_W-1:0]     i_rch,
    input logic [ure_pkg::DIST_W-1:0]   i_dist,
    input logic [ure_pkg::MASK_W-1:0]   i_mask
);
    import ure_pkg::*;

    // nothing comes out in the cycle after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result word valid right after reset");

    // a measurement word carries no timeout mask
    a_meas_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_kind == KIND_MEAS) |-> i_mask == '0)
        else $error("measurement word with timeout bits");

    // timeout word has a nonzero mask and a zero channel, and non-measurement words carry no distance
    a_timeout_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_kind == KIND_TIMEOUT) |->
            (i_mask != '0 && i_dist == '0 && i_rch == '0))
        else $error("timeout word malformed");

    a_none_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_kind == KIND_NONE) |->
            (i_mask == '0 && i_dist == '0 && i_rch == '0))
        else $error("empty word carries data");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_kind) && $stable(i_rch) &&
             $stable(i_dist) && $stable(i_mask)))
        else $error("stalled result word changed");

endmodule

bind ultrasonic_echo_ranger ure_checker u_ure_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_kind      (o_res.kind),
    .i_rch       (o_res.result_channel),
    .i_dist      (o_res.distance_mm),
    .i_mask      (o_res.timeout_mask)
);

### test/tb_ultrasonic_echo_ranger.sv
// testbench of the ultrasonic echo ranger: directed and random command words against a predictor
`timescale 1ns / 1ps

module tb_ultrasonic_echo_ranger;
    import ure_pkg::*;

    localparam int CHANNELS = 4;
    localparam int TIME_W   = 16;

    // indexes past the two real registers, written once to show they do nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef struct {
        t_cmd            op;
        logic [CH_W-1:0] ch;
    } t_cmd_word;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    ure_cmd_if cmd_if ();
    ure_res_if res_if ();

    ultrasonic_echo_ranger DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd_if),
        .o_res      (res_if)
    );

    // predictor state and its copy of the registers
    logic [TIME_W-1:0]  us_now;
    t_mode              ch_mode  [CHANNELS];
    logic [TIME_W-1:0]  armed_at [CHANNELS];
    logic [TIME_W-1:0]  echo_at  [CHANNELS];
    logic [TOUT_W-1:0]  cfg_timeout;
    logic [SPEED_W-1:0] cfg_speed;

    t_cmd_word pending_words [$];
    t_result   expected_readings [$];
    t_cmd_word next_word;
    t_result   want;
    int        words_open;
    int        mismatches;
    int        send_gap_pct;
    int        stall_pct;

    always #5 i_clk = ~i_clk;

    function automatic t_result ranger_step(t_cmd op, logic [CH_W-1:0] ch);
        t_result                   r;
        logic [TIME_W-1:0]         span;
        logic [TIME_W+SPEED_W-1:0] scaled;
        r = '0;
        r.kind = KIND_NONE;
        if (op == CMD_TICK) begin
            us_now = us_now + TIME_W'(1);
            for (int c = 0; c < CHANNELS; c++) begin
                span = us_now - armed_at[c];
                if (ch_mode[c] == MODE_WAIT_END && span > cfg_timeout) begin
                    armed_at[c] = us_now;
                    ch_mode[c] = MODE_WAIT_BEGIN;
                    r.timeout_mask[c] = 1'b1;
                end
            end
            if (r.timeout_mask != '0) begin
                r.kind = KIND_TIMEOUT;
            end
        end else begin
            case (op)
                CMD_ARM: begin
                    armed_at[ch] = us_now;
                    ch_mode[ch] = MODE_WAIT_BEGIN;
                end
                CMD_ECHO_BEGIN: begin
                    if (ch_mode[ch] == MODE_WAIT_BEGIN) begin
                        echo_at[ch] = us_now;
                        ch_mode[ch] = MODE_WAIT_END;
                    end
                end
                default: begin
                    if (ch_mode[ch] == MODE_WAIT_END) begin
                        // pulse width wraps with the counter
                        span = us_now - echo_at[ch];
                        scaled = (TIME_W+SPEED_W)'(span) * (TIME_W+SPEED_W)'(cfg_speed);
                        r.distance_mm = DIST_W'(scaled >> DIST_SHIFT);
                        r.result_channel = ch;
                        r.kind = KIND_MEAS;
                        ch_mode[ch] = MODE_IDLE;
                    end
                end
            endcase
        end
        return r;
    endfunction

    task automatic reset_model();
        us_now = '0;
        cfg_timeout = TIMEOUT_RST;
        cfg_speed = SPEED_RST;
        for (int c = 0; c < CHANNELS; c++) begin
            ch_mode[c] = MODE_IDLE;
            armed_at[c] = '0;
            echo_at[c] = '0;
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_TIMEOUT) begin
            cfg_timeout = data;
        end else if (idx == REG_SPEED) begin
            cfg_speed = data[SPEED_W-1:0];
        end
    endtask

    task automatic queue_word(t_cmd op, logic [CH_W-1:0] ch);
        t_cmd_word w;
        w.op = op;
        w.ch = ch;
        pending_words.push_back(w);
        words_open++;
    endtask

    // mostly arm / begin / end per channel with tick bursts between, plus some noise
    task automatic queue_traffic(int count);
        int n;
        int c;
        int r;
        int burst;
        int stage [CHANNELS];
        n = 0;
        foreach (stage[i]) stage[i] = 0;
        while (n < count) begin
            r = $urandom_range(0, 99);
            if (r < 30) begin
                burst = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                    : $urandom_range(1, 6);
                for (int k = 0; k < burst; k++) begin
                    queue_word(CMD_TICK, CH_W'($urandom_range(0, 3)));
                end
                n += burst;
            end else if (r < 88) begin
                c = $urandom_range(0, CHANNELS - 1);
                case (stage[c])
                    0: queue_word(CMD_ARM, CH_W'(c));
                    1: queue_word(CMD_ECHO_BEGIN, CH_W'(c));
                    default: queue_word(CMD_ECHO_END, CH_W'(c));
                endcase
                stage[c] = (stage[c] + 1) % 3;
                n++;
            end else begin
                queue_word(t_cmd'($urandom_range(0, 3)), CH_W'($urandom_range(0, 3)));
                n++;
            end
        end
    endtask

    task automatic wait_idle();
        while (words_open != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // command driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
        end else begin
            if (cmd_if.valid && cmd_if.ready) begin
                expected_readings.push_back(ranger_step(t_cmd'(cmd_if.command),
                                                        cmd_if.channel));
            end
            if (!cmd_if.valid || cmd_if.ready) begin
                if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
                    next_word = pending_words.pop_front();
                    cmd_if.valid <= 1'b1;
                    cmd_if.command <= next_word.op;
                    cmd_if.channel <= next_word.ch;
                end else begin
                    cmd_if.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (expected_readings.size() == 0) begin
                    $error("result word with none expected");
                    mismatches++;
                end else begin
                    want = expected_readings.pop_front();
                    if (res_if.kind !== want.kind) begin
                        $error("kind expected %0d got %0d", want.kind, res_if.kind);
                        mismatches++;
                    end
                    if (res_if.result_channel !== want.result_channel) begin
                        $error("result_channel expected %0d got %0d",
                               want.result_channel, res_if.result_channel);
                        mismatches++;
                    end
                    if (res_if.distance_mm !== want.distance_mm) begin
                        $error("distance_mm expected %0d got %0d",
                               want.distance_mm, res_if.distance_mm);
                        mismatches++;
                    end
                    if (res_if.timeout_mask !== want.timeout_mask) begin
                        $error("timeout_mask expected %0h got %0h",
                               want.timeout_mask, res_if.timeout_mask);
                        mismatches++;
                    end
                    words_open--;
                end
            end
            res_if.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    initial begin
        #10_000_000;
        $display("tb_ultrasonic_echo_ranger failed");
        $finish;
    end

    initial begin
        logic [TOUT_W-1:0]  tmo_plan   [8];
        logic [SPEED_W-1:0] speed_plan [8];
        logic [CFG_W-1:0]   cfg_word;

        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        cmd_if.valid = 1'b0;
        cmd_if.command = CMD_TICK;
        cmd_if.channel = '0;
        res_if.ready = 1'b0;
        words_open = 0;
        mismatches = 0;
        send_gap_pct = 11;
        stall_pct = 11;
        reset_model();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // default registers: ignored events, zero width, re-arm while waiting end
        queue_word(CMD_TICK, 2'd3);
        queue_word(CMD_ECHO_END, 2'd0);
        queue_word(CMD_ECHO_BEGIN, 2'd1);
        queue_word(CMD_ARM, 2'd0);
        queue_word(CMD_ECHO_END, 2'd0);
        queue_word(CMD_ECHO_BEGIN, 2'd0);
        queue_word(CMD_ECHO_END, 2'd0);
        queue_word(CMD_ARM, 2'd3);
        queue_word(CMD_ECHO_BEGIN, 2'd3);
        repeat (3) queue_word(CMD_TICK, 2'd0);
        queue_word(CMD_ECHO_END, 2'd3);
        queue_word(CMD_ARM, 2'd2);
        queue_word(CMD_ARM, 2'd2);
        queue_word(CMD_ECHO_BEGIN, 2'd2);
        queue_word(CMD_ARM, 2'd2);
        queue_word(CMD_ECHO_END, 2'd2);
        queue_word(CMD_ECHO_BEGIN, 2'd2);
        queue_word(CMD_TICK, 2'd1);
        queue_word(CMD_ECHO_END, 2'd2);
        queue_word(CMD_ECHO_BEGIN, 2'd2);
        wait_idle();

        // zero timeout: all channels at once, then only those waiting end
        write_reg(REG_TIMEOUT, 16'd0);
        write_reg(REG_SPEED, 16'd63);
        for (int c = 0; c < CHANNELS; c++) queue_word(CMD_ARM, CH_W'(c));
        for (int c = 0; c < CHANNELS; c++) queue_word(CMD_ECHO_BEGIN, CH_W'(c));
        queue_word(CMD_TICK, 2'd0);
        queue_word(CMD_ECHO_BEGIN, 2'd1);
        queue_word(CMD_ECHO_BEGIN, 2'd3);
        queue_word(CMD_TICK, 2'd0);
        wait_idle();

        // age equal to the timeout does not expire, one more tick does
        write_reg(REG_TIMEOUT, 16'd2);
        queue_word(CMD_ARM, 2'd0);
        queue_word(CMD_ECHO_BEGIN, 2'd0);
        repeat (3) queue_word(CMD_TICK, 2'd2);
        wait_idle();

        // long pulse under the largest timeout, spare indexes change nothing
        send_gap_pct = 0;
        stall_pct = 0;
        write_reg(REG_TIMEOUT, 16'hFFFF);
        write_reg(REG_SPARE_A, CFG_W'($urandom));
        write_reg(REG_SPARE_B, CFG_W'($urandom));
        queue_word(CMD_ARM, 2'd1);
        queue_word(CMD_ECHO_BEGIN, 2'd1);
        repeat (60) queue_word(CMD_TICK, 2'd0);
        queue_word(CMD_ECHO_END, 2'd1);
        wait_idle();

        tmo_plan[0] = 16'd0;     speed_plan[0] = 6'd1;
        tmo_plan[1] = 16'd3;     speed_plan[1] = 6'd63;
        tmo_plan[2] = 16'd60000; speed_plan[2] = 6'd11;
        tmo_plan[3] = 16'hFFFF;  speed_plan[3] = 6'd0;
        tmo_plan[4] = TOUT_W'($urandom_range(1, 40));
        speed_plan[4] = SPEED_W'($urandom_range(1, 63));
        tmo_plan[5] = TOUT_W'($urandom_range(0, 15));
        speed_plan[5] = 6'd32;
        tmo_plan[6] = TOUT_W'($urandom_range(5, 80));
        speed_plan[6] = SPEED_W'($urandom_range(0, 63));
        tmo_plan[7] = 16'd1;
        speed_plan[7] = SPEED_W'($urandom_range(1, 63));

        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_gap_pct = 0;  stall_pct = 0;  end
                1: begin send_gap_pct = 50; stall_pct = 0;  end
                2: begin send_gap_pct = 0;  stall_pct = 50; end
                default: begin send_gap_pct = 11; stall_pct = 11; end
            endcase
            write_reg(REG_TIMEOUT, tmo_plan[ph]);
            // upper bits of the speed word are don't-care
            cfg_word = CFG_W'($urandom);
            cfg_word[SPEED_W-1:0] = speed_plan[ph];
            write_reg(REG_SPEED, cfg_word);
            queue_traffic(200);
            wait_idle();
        end

        if (mismatches == 0 && expected_readings.size() == 0) begin
            $display("tb_ultrasonic_echo_ranger passed");
        end else begin
            $display("tb_ultrasonic_echo_ranger failed");
        end
        $finish;
    end

endmodule
